// File: hw/rtl/tlr_pkg.sv
package tlr_pkg;

    // configuration register indexes
    localparam logic [0:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_SCREEN_HEIGHT = 1'b1;

    // reset values of the screen size registers
    localparam logic [10:0] SCREEN_WIDTH_RESET  = 11'd480;
    localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd320;

    // item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [9:0]  start_x;
        logic [9:0]  start_y;
        logic [9:0]  end_x;
        logic [9:0]  end_y;
        logic [7:0]  thickness;
        logic [15:0] pen_color;
    } tlr_item_t;

    typedef struct packed {
        logic [9:0]  rect_x;
        logic [9:0]  rect_y;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [15:0] fill_color;
        logic        last_of_line;
    } tlr_rect_t;

    typedef struct packed {
        logic               active;
        logic [9:0]         cur_x;
        logic [9:0]         cur_y;
        logic [9:0]         target_x;
        logic [9:0]         target_y;
        logic signed [10:0] delta_x;
        logic signed [10:0] neg_delta_y;
        logic               step_x_back;
        logic               step_y_back;
        logic signed [11:0] error_term;
        logic [7:0]         held_size;
        logic [15:0]        held_color;
    } tlr_state_t;

    typedef struct packed {
        logic [10:0] screen_width;
        logic [10:0] screen_height;
    } tlr_screen_t;

endpackage

// File: hw/rtl/tlr_cfg.sv
module tlr_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [10:0]           cfg_data,
    output tlr_pkg::tlr_screen_t  screen
);
    import tlr_pkg::*;

    logic [10:0] width_reg;
    logic [10:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    assign screen.screen_width  = width_reg;
    assign screen.screen_height = height_reg;

endmodule

// File: hw/rtl/tlr_step.sv
module tlr_step (
    input  tlr_pkg::tlr_item_t   item,
    input  tlr_pkg::tlr_state_t  st,
    input  tlr_pkg::tlr_screen_t screen,
    output tlr_pkg::tlr_state_t  st_next,
    output logic                 emit,
    output tlr_pkg::tlr_rect_t   rect
);
    import tlr_pkg::*;

    logic [9:0]         abs_dx;
    logic [9:0]         abs_dy;
    logic [9:0]         lo_x;
    logic [9:0]         hi_x;
    logic [9:0]         lo_y;
    logic [9:0]         hi_y;
    logic               off_screen;
    logic signed [10:0] new_dx;
    logic signed [10:0] new_ndy;
    logic signed [12:0] e2;
    logic signed [12:0] ndy_ext;
    logic signed [12:0] dx_ext;
    logic               move_x;
    logic               move_y;
    logic signed [11:0] err_after_x;
    logic [9:0]         x_after;
    logic [9:0]         y_after;

    // start item decode
    assign abs_dx = (item.end_x < item.start_x) ? (item.start_x - item.end_x)
                                                : (item.end_x - item.start_x);
    assign abs_dy = (item.end_y < item.start_y) ? (item.start_y - item.end_y)
                                                : (item.end_y - item.start_y);
    assign lo_x = (item.start_x < item.end_x) ? item.start_x : item.end_x;
    assign hi_x = (item.start_x < item.end_x) ? item.end_x : item.start_x;
    assign lo_y = (item.start_y < item.end_y) ? item.start_y : item.end_y;
    assign hi_y = (item.start_y < item.end_y) ? item.end_y : item.start_y;
    assign off_screen = ({1'b0, item.end_x} >= screen.screen_width)
                     || ({1'b0, item.end_y} >= screen.screen_height);
    assign new_dx  = $signed({1'b0, abs_dx});
    assign new_ndy = -$signed({1'b0, abs_dy});

    // bresenham step decisions, both against the old error term
    assign e2      = {st.error_term, 1'b0};
    assign ndy_ext = {{2{st.neg_delta_y[10]}}, st.neg_delta_y};
    assign dx_ext  = {{2{st.delta_x[10]}}, st.delta_x};
    assign move_x  = (e2 >= ndy_ext);
    assign move_y  = (e2 <= dx_ext);
    assign err_after_x = move_x ? (st.error_term + {st.neg_delta_y[10], st.neg_delta_y})
                                : st.error_term;
    assign x_after = move_x ? (st.step_x_back ? st.cur_x - 10'd1 : st.cur_x + 10'd1)
                            : st.cur_x;
    assign y_after = move_y ? (st.step_y_back ? st.cur_y - 10'd1 : st.cur_y + 10'd1)
                            : st.cur_y;

    always_comb
    begin
        st_next = st;
        emit    = 1'b0;
        rect.rect_x       = st.cur_x;
        rect.rect_y       = st.cur_y;
        rect.rect_width   = {3'd0, st.held_size};
        rect.rect_height  = {3'd0, st.held_size};
        rect.fill_color   = st.held_color;
        rect.last_of_line = 1'b0;

        if (item.kind == KIND_START)
        begin
            st_next.active = 1'b0;
            rect.fill_color = item.pen_color;
            if (off_screen)
            begin
                emit = 1'b0;
            end
            else if (item.start_x == item.end_x)
            begin
                // vertical line or single point
                emit = 1'b1;
                rect.rect_x       = item.start_x;
                rect.rect_y       = lo_y;
                rect.rect_width   = {3'd0, item.thickness};
                rect.rect_height  = {1'b0, hi_y - lo_y} + 11'd1;
                rect.last_of_line = 1'b1;
            end
            else if (item.start_y == item.end_y)
            begin
                // horizontal line
                emit = 1'b1;
                rect.rect_x       = lo_x;
                rect.rect_y       = item.start_y;
                rect.rect_width   = {1'b0, hi_x - lo_x} + 11'd1;
                rect.rect_height  = {3'd0, item.thickness};
                rect.last_of_line = 1'b1;
            end
            else
            begin
                emit = 1'b1;
                st_next.active      = 1'b1;
                st_next.cur_x       = item.start_x;
                st_next.cur_y       = item.start_y;
                st_next.target_x    = item.end_x;
                st_next.target_y    = item.end_y;
                st_next.step_x_back = item.end_x < item.start_x;
                st_next.step_y_back = item.end_y < item.start_y;
                st_next.delta_x     = new_dx;
                st_next.neg_delta_y = new_ndy;
                st_next.error_term  = {new_dx[10], new_dx} + {new_ndy[10], new_ndy};
                st_next.held_size   = item.thickness;
                st_next.held_color  = item.pen_color;
                rect.rect_x       = item.start_x;
                rect.rect_y       = item.start_y;
                rect.rect_width   = {3'd0, item.thickness};
                rect.rect_height  = {3'd0, item.thickness};
            end
        end
        else if (st.active)
        begin
            if (move_x && (st.cur_x == st.target_x))
            begin
                // guard stop on x, nothing moves
                st_next.active = 1'b0;
            end
            else if (move_y && (st.cur_y == st.target_y))
            begin
                // guard stop on y, an x move already made stays
                st_next.active     = 1'b0;
                st_next.cur_x      = x_after;
                st_next.error_term = err_after_x;
            end
            else
            begin
                emit = 1'b1;
                st_next.cur_x      = x_after;
                st_next.cur_y      = y_after;
                st_next.error_term = move_y
                    ? (err_after_x + {st.delta_x[10], st.delta_x})
                    : err_after_x;
                rect.rect_x = x_after;
                rect.rect_y = y_after;
                if ((x_after == st.target_x) && (y_after == st.target_y))
                begin
                    rect.last_of_line = 1'b1;
                    st_next.active    = 1'b0;
                end
            end
        end
    end

endmodule

// File: hw/rtl/thick_line_rasterizer_core.sv
// Thick line rasterizer: turns line requests into fill rectangles for a square pen.
// A start transaction (kind 0) loads both endpoints, the pen thickness and the color;
// a line whose end point falls outside screen_width x screen_height is dropped, a
// vertical or horizontal line comes out at once as one rectangle marked last, and
// any other line gives the square at its start point. Each advance transaction
// (kind 1) then moves the pen one Bresenham step and gives the square at the new
// point, marked last at the end point; an advance with no line in progress gives
// nothing. One transaction is taken every clock while in_stall is low; its result
// passes through the input register and then the result register, around the
// single step of error-term update. Screen size writes are taken at any time but
// belong only in idle periods. Rectangles are not clipped to the screen.
module thick_line_rasterizer_core (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [9:0]  start_x,
    input  logic [9:0]  start_y,
    input  logic [9:0]  end_x,
    input  logic [9:0]  end_y,
    input  logic [7:0]  thickness,
    input  logic [15:0] pen_color,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  rect_x,
    output logic [9:0]  rect_y,
    output logic [10:0] rect_width,
    output logic [10:0] rect_height,
    output logic [15:0] fill_color,
    output logic        last_of_line,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import tlr_pkg::*;

    tlr_screen_t screen;
    tlr_item_t   item_reg;
    logic        item_valid_reg;
    tlr_state_t  state_reg;
    tlr_state_t  state_next;
    tlr_rect_t   rect_reg;
    tlr_rect_t   rect_next;
    logic        out_valid_reg;
    logic        emit;
    logic        out_free;
    logic        process;

    // screen size registers
    tlr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .screen    (screen)
    );

    // the result register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // the held item is worked on once there is room for its result
    assign process  = item_valid_reg && out_free;
    // hold off new transactions only while the held item cannot move on
    assign in_stall = item_valid_reg && !out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.kind      <= kind;
            item_reg.start_x   <= start_x;
            item_reg.start_y   <= start_y;
            item_reg.end_x     <= end_x;
            item_reg.end_y     <= end_y;
            item_reg.thickness <= thickness;
            item_reg.pen_color <= pen_color;
        end
    end

    // one step of line decode or bresenham advance
    tlr_step u_step (
        .item    (item_reg),
        .st      (state_reg),
        .screen  (screen),
        .st_next (state_next),
        .emit    (emit),
        .rect    (rect_next)
    );

    // line state, updated as each held item is worked on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (process)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= process && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && emit)
        begin
            rect_reg <= rect_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rect_x       = rect_reg.rect_x;
    assign rect_y       = rect_reg.rect_y;
    assign rect_width   = rect_reg.rect_width;
    assign rect_height  = rect_reg.rect_height;
    assign fill_color   = rect_reg.fill_color;
    assign last_of_line = rect_reg.last_of_line;

endmodule
